@@ hw/rtl/hffm_pkg.sv @@
// Shared types and constants of the header frame finder.
`default_nettype none

package hffm_pkg;

   // Field widths fixed by the transaction format
   localparam int BYTE_W = 8;
   localparam int OP_W   = 2;
   localparam int STAT_W = 3;
   localparam int LEN_W  = 9;
   localparam int BODY_W = 16;
   localparam int TOT_W  = 17;
   localparam int CMP_W  = TOT_W + 1;

   // Header bytes
   localparam logic [BYTE_W-1:0] HDR_FIX_0 = 8'hA5;
   localparam logic [BYTE_W-1:0] HDR_FIX_1 = 8'h5A;
   localparam logic [BYTE_W-1:0] HDR_SYNC  = 8'hAA;

   // Headed frame geometry
   localparam int HDR_MIN_SPAN = 13;
   localparam int HDR_OVERHEAD = 11;
   localparam int HDR_LAST_OFS = 9;
   localparam int WIN_LEN      = 9;

   // Fixed mode shortest frame
   localparam logic [LEN_W-1:0] MIN_FIX_LEN = 9'd2;

   // Register indexes
   localparam logic REG_MODE   = 1'b0;
   localparam logic REG_FIXLEN = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_IDLE = 2'd1,
      OP_READ = 2'd2,
      OP_NOP  = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_STORED  = 3'd0,
      ST_DROPPED = 3'd1,
      ST_FOUND   = 3'd2,
      ST_NONE    = 3'd3,
      ST_READ    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_COPY,
      FSM_REPLY
   } fsm_type;

   typedef struct packed {
      logic             frame_mode;
      logic [LEN_W-1:0] fixed_frame_len;
   } cfg_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [LEN_W-1:0]  frame_length;
      logic              frame_held;
      logic [BYTE_W-1:0] read_data;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/hffm_ram.sv @@
// Single-port-write, single-port-read synchronous byte memory with a registered read.
`default_nettype none

module hffm_ram #(
   parameter int DEPTH = 256
) (
   input  wire logic                         clock,
   input  wire logic                         we,
   input  wire logic [$clog2(DEPTH)-1:0]     waddr,
   input  wire logic [hffm_pkg::BYTE_W-1:0]  wdata,
   input  wire logic                         re,
   input  wire logic [$clog2(DEPTH)-1:0]     raddr,
   output      logic [hffm_pkg::BYTE_W-1:0]  rdata
);

   logic [hffm_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [hffm_pkg::BYTE_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/hffm_seq.sv @@
// Sequencer: burst capture, frame search, frame copy and frame read-back.
`default_nettype none

module hffm_seq #(
   parameter int RX_DEPTH    = 256,
   parameter int FRAME_DEPTH = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire hffm_pkg::cfg_type                    cfg,
   input  wire logic                                 in_valid,
   output      logic                                 in_ready,
   input  wire hffm_pkg::req_type                    req,
   input  wire logic                                 slot_free,
   output      logic                                 out_load,
   output      hffm_pkg::rsp_type                    out_rsp,
   // receive store
   output      logic                                 rx_we,
   output      logic [$clog2(RX_DEPTH)-1:0]          rx_waddr,
   output      logic [hffm_pkg::BYTE_W-1:0]          rx_wdata,
   output      logic                                 rx_re,
   output      logic [$clog2(RX_DEPTH)-1:0]          rx_raddr,
   input  wire logic [hffm_pkg::BYTE_W-1:0]          rx_rdata,
   // frame store
   output      logic                                 fr_we,
   output      logic [$clog2(FRAME_DEPTH)-1:0]       fr_waddr,
   output      logic [hffm_pkg::BYTE_W-1:0]          fr_wdata,
   output      logic                                 fr_re,
   output      logic [$clog2(FRAME_DEPTH)-1:0]       fr_raddr,
   input  wire logic [hffm_pkg::BYTE_W-1:0]          fr_rdata
);

   localparam int CntW  = $clog2(RX_DEPTH + 1);
   localparam int RxAw  = $clog2(RX_DEPTH);
   localparam int LenHW = $clog2(FRAME_DEPTH + 1);
   localparam int FrAw  = $clog2(FRAME_DEPTH);
   localparam int CmpW  = hffm_pkg::CMP_W;
   localparam int LenW  = hffm_pkg::LEN_W;
   localparam int ByteW = hffm_pkg::BYTE_W;
   localparam int WinN  = hffm_pkg::WIN_LEN;

   hffm_pkg::fsm_type    state_ff, state_in;
   logic [CntW-1:0]      rx_count_ff, rx_count_in;
   logic [LenHW-1:0]     held_len_ff, held_len_in;
   logic                 held_flag_ff, held_flag_in;
   logic [CntW-1:0]      iss_ff, iss_in;
   logic                 vld_ff, vld_in;
   logic [CntW-1:0]      pos_ff, pos_in;
   logic [ByteW-1:0]     win_ff [WinN];
   logic [ByteW-1:0]     win_in [WinN];
   logic [RxAw-1:0]      start_ff, start_in;
   logic [LenHW-1:0]     cap_len_ff, cap_len_in;
   logic [LenHW-1:0]     wr_ff, wr_in;
   hffm_pkg::status_type res_ff, res_in;
   logic                 rd_hit_ff, rd_hit_in;

   logic                 accept;
   logic [LenW-1:0]      len0;
   logic [CmpW-1:0]      len0_c, count_c, pos_c, total_c;
   logic [CmpW-1:0]      fix_start_c, hdr_start_c, found_start_c;
   logic                 fix_match, fix_fits, hdr_cand, hdr_fits;
   logic                 scan_found, scan_none, copy_done;

   assign accept = in_valid && in_ready;

   // ---------------------------------------------------------------
   // Candidate evaluation on the byte arriving from the receive store
   always_comb begin
      len0    = (cfg.fixed_frame_len < hffm_pkg::MIN_FIX_LEN) ?
                hffm_pkg::MIN_FIX_LEN : cfg.fixed_frame_len;
      len0_c  = CmpW'(len0);
      count_c = CmpW'(rx_count_ff);
      pos_c   = CmpW'(pos_ff);

      // fixed mode: A5 5A ending at this byte
      fix_start_c = pos_c - CmpW'(1);
      fix_match   = vld_ff && (pos_ff != '0) && (win_ff[0] == hffm_pkg::HDR_FIX_0)
                    && (rx_rdata == hffm_pkg::HDR_FIX_1);
      fix_fits    = (fix_start_c + len0_c) <= count_c;

      // headed mode: this byte is the length high byte of a candidate
      hdr_start_c = pos_c - CmpW'(hffm_pkg::HDR_LAST_OFS);
      total_c     = CmpW'({rx_rdata, win_ff[0]}) + CmpW'(hffm_pkg::HDR_OVERHEAD);
      hdr_cand    = vld_ff && (pos_c >= CmpW'(hffm_pkg::HDR_LAST_OFS))
                    && ((hdr_start_c + CmpW'(hffm_pkg::HDR_MIN_SPAN)) < count_c)
                    && (win_ff[8] == hffm_pkg::HDR_SYNC) && (win_ff[7] == hffm_pkg::HDR_SYNC)
                    && (win_ff[6] == hffm_pkg::HDR_SYNC) && (win_ff[5] == hffm_pkg::HDR_SYNC);
      hdr_fits    = ((count_c - hdr_start_c) >= total_c) && (total_c <= CmpW'(FRAME_DEPTH));

      if (cfg.frame_mode) begin
         scan_found    = hdr_cand && hdr_fits;
         scan_none     = !vld_ff && (iss_ff == rx_count_ff);
         found_start_c = hdr_start_c;
      end else begin
         scan_found    = fix_match && fix_fits && (len0_c <= CmpW'(FRAME_DEPTH));
         scan_none     = (len0_c > CmpW'(FRAME_DEPTH)) || (fix_match && !fix_fits)
                         || (!vld_ff && (iss_ff == rx_count_ff));
         found_start_c = fix_start_c;
      end

      copy_done = vld_ff && ((wr_ff + LenHW'(1)) == cap_len_ff);
   end

   // ---------------------------------------------------------------
   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hffm_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = (req.opcode == hffm_pkg::OP_IDLE) ? hffm_pkg::FSM_SCAN
                                                             : hffm_pkg::FSM_REPLY;
            end
         end
         hffm_pkg::FSM_SCAN: begin
            if (scan_found) begin
               state_in = hffm_pkg::FSM_COPY;
            end else if (scan_none) begin
               state_in = hffm_pkg::FSM_REPLY;
            end
         end
         hffm_pkg::FSM_COPY: begin
            if (copy_done) begin
               state_in = hffm_pkg::FSM_REPLY;
            end
         end
         hffm_pkg::FSM_REPLY: begin
            if (slot_free) begin
               state_in = hffm_pkg::FSM_IDLE;
            end
         end
         default: state_in = hffm_pkg::FSM_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath and memory port control
   always_comb begin
      rx_count_in  = rx_count_ff;
      held_len_in  = held_len_ff;
      held_flag_in = held_flag_ff;
      iss_in       = iss_ff;
      vld_in       = 1'b0;
      pos_in       = pos_ff;
      win_in       = win_ff;
      start_in     = start_ff;
      cap_len_in   = cap_len_ff;
      wr_in        = wr_ff;
      res_in       = res_ff;
      rd_hit_in    = rd_hit_ff;

      in_ready = (state_ff == hffm_pkg::FSM_IDLE);
      out_load = 1'b0;
      out_rsp.status       = res_ff;
      out_rsp.frame_length = LenW'(held_len_ff);
      out_rsp.frame_held   = held_flag_ff;
      out_rsp.read_data    = rd_hit_ff ? fr_rdata : '0;

      rx_we    = 1'b0;
      rx_waddr = rx_count_ff[RxAw-1:0];
      rx_wdata = req.rx_byte;
      rx_re    = 1'b0;
      rx_raddr = iss_ff[RxAw-1:0];
      fr_we    = 1'b0;
      fr_waddr = wr_ff[FrAw-1:0];
      fr_wdata = rx_rdata;
      fr_re    = 1'b0;
      fr_raddr = FrAw'(req.read_index);

      case (state_ff)
         hffm_pkg::FSM_IDLE: begin
            if (accept) begin
               rd_hit_in = 1'b0;
               res_in    = hffm_pkg::ST_READ;
               case (req.opcode)
                  hffm_pkg::OP_PUSH: begin
                     if (rx_count_ff < CntW'(RX_DEPTH)) begin
                        rx_we       = 1'b1;
                        rx_count_in = rx_count_ff + CntW'(1);
                        res_in      = hffm_pkg::ST_STORED;
                     end else begin
                        res_in = hffm_pkg::ST_DROPPED;
                     end
                  end
                  hffm_pkg::OP_IDLE: begin
                     iss_in = '0;
                     pos_in = '0;
                  end
                  hffm_pkg::OP_READ: begin
                     fr_re     = 1'b1;
                     rd_hit_in = (CmpW'(req.read_index) < CmpW'(held_len_ff))
                                 && (CmpW'(req.read_index) < CmpW'(FRAME_DEPTH));
                  end
                  default: ;
               endcase
            end
         end

         hffm_pkg::FSM_SCAN: begin
            // shift the arriving byte into the window
            if (vld_ff) begin
               win_in[0] = rx_rdata;
               for (int k = 1; k < WinN; k++) begin
                  win_in[k] = win_ff[k-1];
               end
            end
            if (scan_found) begin
               start_in   = RxAw'(found_start_c);
               cap_len_in = cfg.frame_mode ? LenHW'(total_c) : LenHW'(len0_c);
               iss_in     = '0;
               wr_in      = '0;
            end else if (scan_none) begin
               res_in      = hffm_pkg::ST_NONE;
               rd_hit_in   = 1'b0;
               rx_count_in = '0;
            end else if (iss_ff < rx_count_ff) begin
               rx_re  = 1'b1;
               iss_in = iss_ff + CntW'(1);
               vld_in = 1'b1;
               pos_in = iss_ff;
            end
         end

         hffm_pkg::FSM_COPY: begin
            rx_raddr = RxAw'(CmpW'(start_ff) + CmpW'(iss_ff));
            if (CmpW'(iss_ff) < CmpW'(cap_len_ff)) begin
               rx_re  = 1'b1;
               iss_in = iss_ff + CntW'(1);
               vld_in = 1'b1;
            end
            if (vld_ff) begin
               fr_we = 1'b1;
               wr_in = wr_ff + LenHW'(1);
            end
            if (copy_done) begin
               vld_in       = 1'b0;
               held_len_in  = cap_len_ff;
               held_flag_in = 1'b1;
               res_in       = hffm_pkg::ST_FOUND;
               rd_hit_in    = 1'b0;
               rx_count_in  = '0;
            end
         end

         hffm_pkg::FSM_REPLY: begin
            out_load = slot_free;
         end

         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hffm_pkg::FSM_IDLE;
         rx_count_ff  <= '0;
         held_len_ff  <= '0;
         held_flag_ff <= 1'b0;
         vld_ff       <= 1'b0;
         rd_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rx_count_ff  <= rx_count_in;
         held_len_ff  <= held_len_in;
         held_flag_ff <= held_flag_in;
         vld_ff       <= vld_in;
         rd_hit_ff    <= rd_hit_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      iss_ff     <= iss_in;
      pos_ff     <= pos_in;
      win_ff     <= win_in;
      start_ff   <= start_in;
      cap_len_ff <= cap_len_in;
      wr_ff      <= wr_in;
      res_ff     <= res_in;
   end

   // ---------------------------------------------------------------
   // Checks
   a_held_sticky: assert property (@(posedge clock) disable iff (reset)
      held_flag_ff |=> held_flag_ff)
      else $error("frame held flag dropped");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= CntW'(RX_DEPTH))
      else $error("receive count beyond store depth");

   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      fr_we |-> (CmpW'(wr_ff) < CmpW'(cap_len_ff)))
      else $error("frame copy wrote past frame length");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> !in_ready)
      else $error("second transaction taken while one is in progress");

endmodule

`default_nettype wire

@@ hw/rtl/header_frame_finder_two_mode_unit.sv @@
// Header frame finder: request and response channels, register port and stores.
//
// Request channel (req_): one transaction per operation. req_tuser carries the
// opcode (push received byte, end of burst, read frame byte), req_tdata the
// received byte and the frame read index. Every request gives one response on
// rsp_ with a status in rsp_tuser and the held frame length, held flag and
// read data in rsp_tdata.
// Push, read and unused opcodes pass through the reply state and the output
// register to rsp_tvalid. End of burst walks the receive store one byte a
// cycle through its single read port to search it, then copies a found frame
// into the frame store before its response.
// Only one transaction is in progress at a time: req_tready is high while the
// sequencer is idle. The response sits in an output register; if the receiver
// stalls, the sequencer holds its finished result and takes no new request
// until the register frees.
// Reset clears the burst count, held length and held flag and sets mode 0 with
// a frame length of 8; the stores themselves are not cleared. Registers are
// written through the APB-style port; the user must write them only while no
// transaction is in progress, as the block itself does not enforce this.
`default_nettype none

module header_frame_finder_two_mode_unit #(
   parameter int RX_DEPTH    = 256,
   parameter int FRAME_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] read_index
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   // response channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [8:0] frame_length, [9] frame_held,
                                         // [17:10] read_data, [23:18] zero
   output      logic [2:0]  rsp_tuser,   // [2:0] status
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int RxAw  = $clog2(RX_DEPTH);
   localparam int FrAw  = $clog2(FRAME_DEPTH);
   localparam int ByteW = hffm_pkg::BYTE_W;
   localparam int LenW  = hffm_pkg::LEN_W;

   logic                 mode_ff, mode_in;
   logic [LenW-1:0]      fixlen_ff, fixlen_in;
   logic                 out_valid_ff, out_valid_in;
   hffm_pkg::rsp_type    out_rsp_ff, out_rsp_in;

   hffm_pkg::cfg_type    cfg;
   hffm_pkg::req_type    req;
   hffm_pkg::rsp_type    seq_rsp;
   logic                 seq_load;
   logic                 slot_free;
   logic                 csr_wr;

   logic                 rx_we, rx_re, fr_we, fr_re;
   logic [RxAw-1:0]      rx_waddr, rx_raddr;
   logic [FrAw-1:0]      fr_waddr, fr_raddr;
   logic [ByteW-1:0]     rx_wdata, rx_rdata, fr_wdata, fr_rdata;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in   = mode_ff;
      fixlen_in = fixlen_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == hffm_pkg::REG_MODE) begin
            mode_in = csr_pwdata[0];
         end else begin
            fixlen_in = csr_pwdata[LenW-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == hffm_pkg::REG_FIXLEN) begin
         csr_prdata = 32'(fixlen_ff);
      end else begin
         csr_prdata = 32'(mode_ff);
      end
   end

   assign cfg.frame_mode      = mode_ff;
   assign cfg.fixed_frame_len = fixlen_ff;

   // request unpacking
   assign req.opcode     = hffm_pkg::opcode_type'(req_tuser);
   assign req.rx_byte    = req_tdata[7:0];
   assign req.read_index = req_tdata[15:8];

   // output register
   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (seq_load) begin
         out_valid_in = 1'b1;
         out_rsp_in   = seq_rsp;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         fixlen_ff    <= 9'd8;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         fixlen_ff    <= fixlen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_rsp_ff.status;
   assign rsp_tdata  = {6'b0, out_rsp_ff.read_data, out_rsp_ff.frame_held,
                        out_rsp_ff.frame_length};

   // sequencer
   hffm_seq #(
      .RX_DEPTH    (RX_DEPTH),
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .req       (req),
      .slot_free (slot_free),
      .out_load  (seq_load),
      .out_rsp   (seq_rsp),
      .rx_we     (rx_we),
      .rx_waddr  (rx_waddr),
      .rx_wdata  (rx_wdata),
      .rx_re     (rx_re),
      .rx_raddr  (rx_raddr),
      .rx_rdata  (rx_rdata),
      .fr_we     (fr_we),
      .fr_waddr  (fr_waddr),
      .fr_wdata  (fr_wdata),
      .fr_re     (fr_re),
      .fr_raddr  (fr_raddr),
      .fr_rdata  (fr_rdata)
   );

   // receive store
   hffm_ram #(
      .DEPTH (RX_DEPTH)
   ) u_rx_store (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_waddr),
      .wdata (rx_wdata),
      .re    (rx_re),
      .raddr (rx_raddr),
      .rdata (rx_rdata)
   );

   // frame store
   hffm_ram #(
      .DEPTH (FRAME_DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (fr_we),
      .waddr (fr_waddr),
      .wdata (fr_wdata),
      .re    (fr_re),
      .raddr (fr_raddr),
      .rdata (fr_rdata)
   );

endmodule

`default_nettype wire
